FILE: design/fps_pkg.sv
package fps_pkg;

    // Widths fixed by the register and stream definitions
    localparam int unsigned CFG_DIM_W    = 13;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned APB_ADDR_W   = 4;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PIXEL_W      = 32;
    localparam int unsigned WORD_W       = 64;
    localparam int unsigned WORD_IDX_W   = 4;
    localparam int unsigned LUMA_PIX_W   = 24;

    // Default frame limits
    localparam int unsigned FPS_MAX_WIDTH  = 4096;
    localparam int unsigned FPS_MAX_HEIGHT = 4096;

    // Q16 luma weights (0.299, 0.587, 0.114)
    localparam int unsigned LUMA_WR = 19595;
    localparam int unsigned LUMA_WG = 38470;
    localparam int unsigned LUMA_WB = 7471;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_ORDER  = 2'd2;

    // Report word indexes
    localparam logic [WORD_IDX_W-1:0] WORD_BYTE_COUNT   = 4'd0;
    localparam logic [WORD_IDX_W-1:0] WORD_BYTE_SUM     = 4'd1;
    localparam logic [WORD_IDX_W-1:0] WORD_NZ_BYTES     = 4'd2;
    localparam logic [WORD_IDX_W-1:0] WORD_NZ_PIXELS    = 4'd3;
    localparam logic [WORD_IDX_W-1:0] WORD_LUMA_AVG     = 4'd4;
    localparam logic [WORD_IDX_W-1:0] WORD_LEAD_LO      = 4'd5;
    localparam logic [WORD_IDX_W-1:0] WORD_LEAD_HI      = 4'd6;
    localparam logic [WORD_IDX_W-1:0] WORD_CENTRE       = 4'd7;
    localparam logic [WORD_IDX_W-1:0] WORD_CORNERS_TOP  = 4'd8;
    localparam logic [WORD_IDX_W-1:0] WORD_CORNERS_BOT  = 4'd9;

    typedef struct packed {
        logic                  accept;
        logic                  clear;
        logic                  div_start;
        logic                  send;
        logic [WORD_IDX_W-1:0] word_idx;
    } t_fps_cmd;

    typedef struct packed {
        logic frame_end;
        logic out_free;
        logic div_busy;
    } t_fps_stat;

endpackage

FILE: design/frame_pixel_statistics_core.sv
// Channel   Direction  Handshake                  Payload
// pixel     in         i_in_valid / o_in_ready    i_byte_zero..i_byte_three (8b each)
// report    out        o_out_valid / i_out_ready  o_word_index, o_word_value, o_last_word
// config    in         APB psel/penable/pwrite    paddr[3:0], pwdata, prdata, pready
//
// Pixels stream back to back within a frame.
// The last pixel of a frame starts the report: a flush state, a load state,
// the luma divider (one quotient bit a cycle, 50 bits at the default limits), then ten
// words; o_in_ready stays low until the last word has been handed to the output
// register, so no pixel of the next frame is taken while the report is pending.
// Reset is synchronous, active low; it clears counters, accumulators and control.
// A stalled sink holds the report word in the output register and holds the sequencer.
module frame_pixel_statistics_core import fps_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = FPS_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = FPS_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel stream
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_byte_zero,
    input  logic [BYTE_W-1:0]     i_byte_one,
    input  logic [BYTE_W-1:0]     i_byte_two,
    input  logic [BYTE_W-1:0]     i_byte_three,
    // report stream
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [WORD_IDX_W-1:0] o_word_index,
    output logic [WORD_W-1:0]     o_word_value,
    output logic                  o_last_word,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_DIM_W-1:0] r_frame_width;
    logic [CFG_DIM_W-1:0] r_frame_height;
    logic                 r_pixel_order;
    logic [1:0]           reg_idx;
    logic                 reg_wr;

    t_fps_cmd  cmd;
    t_fps_stat stat;

    // Registers sit on word addresses; the slave never inserts wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign reg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DIM_W'(1);
            r_frame_height <= CFG_DIM_W'(1);
            r_pixel_order  <= 1'b0;
        end else if (reg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_DIM_W-1:0];
                REG_PIXEL_ORDER:  r_pixel_order  <= pwdata[0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // Read back the raw register contents, not the clamped values
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            REG_PIXEL_ORDER:  prdata = APB_DATA_W'(r_pixel_order);
            default:          prdata = '0;
        endcase
    end

    // Sequencer: owns the input handshake and steps through the report
    fps_ctrl u_fps_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Accumulators, captures, luma divider and output register
    fps_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_fps_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_width  (r_frame_width),
        .i_cfg_height (r_frame_height),
        .i_cfg_order  (r_pixel_order),
        .i_byte_zero  (i_byte_zero),
        .i_byte_one   (i_byte_one),
        .i_byte_two   (i_byte_two),
        .i_byte_three (i_byte_three),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_last_word  (o_last_word)
    );

endmodule

FILE: design/fps_div.sv
module fps_div import fps_pkg::*; #(
    parameter int unsigned DVD_W = 48,
    parameter int unsigned DVS_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;
    logic             q_bit;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        rem_sh = {r_rem[DVS_W-1:0], r_dvd[DVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        q_bit  = ~diff[DVS_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DVS_W:0] : rem_sh;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_dvd;

endmodule

FILE: design/fps_dpath.sv
module fps_dpath import fps_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = FPS_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = FPS_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DIM_W-1:0]  i_cfg_width,
    input  logic [CFG_DIM_W-1:0]  i_cfg_height,
    input  logic                  i_cfg_order,
    input  logic [BYTE_W-1:0]     i_byte_zero,
    input  logic [BYTE_W-1:0]     i_byte_one,
    input  logic [BYTE_W-1:0]     i_byte_two,
    input  logic [BYTE_W-1:0]     i_byte_three,
    input  t_fps_cmd              i_cmd,
    output t_fps_stat             o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [WORD_IDX_W-1:0] o_word_index,
    output logic [WORD_W-1:0]     o_word_value,
    output logic                  o_last_word
);

    localparam int unsigned DWW   = $clog2(MAX_WIDTH + 1);
    localparam int unsigned DWH   = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned PW    = DWW + DWH;
    localparam int unsigned NZB_W = PW + 2;
    localparam int unsigned LW    = PW + LUMA_PIX_W;

    logic [DWW-1:0] w_eff;
    logic [DWH-1:0] h_eff;
    logic [PW-1:0]  r_area;

    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           row_end;
    logic           frame_end;
    logic           col_last;
    logic           row_last;

    logic [PIXEL_W-1:0]    pix;
    logic [BYTE_W-1:0]     red;
    logic [BYTE_W-1:0]     blue;
    logic [LUMA_PIX_W-1:0] luma_pix;
    logic [2:0]            nz_cnt;

    logic [WORD_W-1:0]     r_byte_sum;
    logic [NZB_W-1:0]      r_nz_bytes;
    logic [PW-1:0]         r_nz_pixels;
    logic [LW-1:0]         r_luma;
    logic [LUMA_PIX_W-1:0] r_luma_pix;
    logic                  r_luma_pend;

    logic [PIXEL_W-1:0] r_lead [4];
    logic [1:0]         lead_sel;
    logic [PIXEL_W-1:0] r_centre;
    logic [PIXEL_W-1:0] r_corner [4];

    logic              div_busy;
    logic [LW-1:0]     quotient;

    logic                  r_out_valid;
    logic [WORD_IDX_W-1:0] r_out_index;
    logic [WORD_W-1:0]     r_out_value;
    logic                  r_out_last;
    logic                  out_free;
    logic [WORD_W-1:0]     word_mux;

    // Clamp the frame size into 1..MAX
    always_comb begin
        if (i_cfg_width == '0) begin
            w_eff = DWW'(1);
        end else if (32'(i_cfg_width) > MAX_WIDTH) begin
            w_eff = DWW'(MAX_WIDTH);
        end else begin
            w_eff = DWW'(i_cfg_width);
        end
        if (i_cfg_height == '0) begin
            h_eff = DWH'(1);
        end else if (32'(i_cfg_height) > MAX_HEIGHT) begin
            h_eff = DWH'(MAX_HEIGHT);
        end else begin
            h_eff = DWH'(i_cfg_height);
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= PW'(w_eff) * PW'(h_eff);
    end

    // Raster position
    always_comb begin
        col_last  = (32'(r_col) + 32'd1 == 32'(w_eff));
        row_last  = (32'(r_row) + 32'd1 == 32'(h_eff));
        row_end   = (32'(r_col) + 32'd1 >= 32'(w_eff));
        frame_end = row_end && (32'(r_row) + 32'd1 >= 32'(h_eff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Per-pixel terms
    always_comb begin
        pix      = {i_byte_three, i_byte_two, i_byte_one, i_byte_zero};
        red      = i_cfg_order ? i_byte_zero : i_byte_two;
        blue     = i_cfg_order ? i_byte_two : i_byte_zero;
        luma_pix = LUMA_PIX_W'(LUMA_WR * 32'(red) + LUMA_WG * 32'(i_byte_one)
                               + LUMA_WB * 32'(blue));
        nz_cnt   = 3'(i_byte_zero != '0) + 3'(i_byte_one != '0)
                 + 3'(i_byte_two != '0) + 3'(i_byte_three != '0);
        lead_sel = 2'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_sum  <= '0;
            r_nz_bytes  <= '0;
            r_nz_pixels <= '0;
            r_luma      <= '0;
            r_luma_pend <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_lead[k] <= '0;
            end
        end else if (i_cmd.clear) begin
            r_byte_sum  <= '0;
            r_nz_bytes  <= '0;
            r_nz_pixels <= '0;
            r_luma      <= '0;
            r_luma_pend <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_lead[k] <= '0;
            end
        end else begin
            r_luma_pend <= i_cmd.accept;
            if (r_luma_pend) begin
                r_luma <= r_luma + LW'(r_luma_pix);
            end
            if (i_cmd.accept) begin
                r_byte_sum <= r_byte_sum + WORD_W'(i_byte_zero) + WORD_W'(i_byte_one)
                            + WORD_W'(i_byte_two) + WORD_W'(i_byte_three);
                r_nz_bytes <= r_nz_bytes + NZB_W'(nz_cnt);
                if ((i_byte_zero | i_byte_one | i_byte_two) != '0) begin
                    r_nz_pixels <= r_nz_pixels + 1'b1;
                end
                if (r_row == '0 && 32'(r_col) < 32'd4) begin
                    r_lead[lead_sel] <= pix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_luma_pix <= luma_pix;
    end

    // Centre and corner captures; a pixel may land in several
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (32'(r_col) == 32'(w_eff >> 1) && 32'(r_row) == 32'(h_eff >> 1)) begin
                r_centre <= pix;
            end
            if (r_row == '0 && r_col == '0) begin
                r_corner[0] <= pix;
            end
            if (r_row == '0 && col_last) begin
                r_corner[1] <= pix;
            end
            if (row_last && r_col == '0) begin
                r_corner[2] <= pix;
            end
            if (row_last && col_last) begin
                r_corner[3] <= pix;
            end
        end
    end

    fps_div #(
        .DVD_W (LW),
        .DVS_W (PW)
    ) u_fps_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_luma),
        .i_divisor  (r_area),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Report word select
    always_comb begin
        unique case (i_cmd.word_idx)
            WORD_BYTE_COUNT:  word_mux = WORD_W'(r_area) << 2;
            WORD_BYTE_SUM:    word_mux = r_byte_sum;
            WORD_NZ_BYTES:    word_mux = WORD_W'(r_nz_bytes);
            WORD_NZ_PIXELS:   word_mux = WORD_W'(r_nz_pixels);
            WORD_LUMA_AVG:    word_mux = WORD_W'(quotient);
            WORD_LEAD_LO:     word_mux = {r_lead[1], r_lead[0]};
            WORD_LEAD_HI:     word_mux = {r_lead[3], r_lead[2]};
            WORD_CENTRE:      word_mux = WORD_W'(r_centre);
            WORD_CORNERS_TOP: word_mux = {r_corner[1], r_corner[0]};
            WORD_CORNERS_BOT: word_mux = {r_corner[3], r_corner[2]};
            default:          word_mux = '0;
        endcase
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_cmd.send;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            r_out_index <= i_cmd.word_idx;
            r_out_value <= word_mux;
            r_out_last  <= (i_cmd.word_idx == WORD_CORNERS_BOT);
        end
    end

    always_comb begin
        o_stat.frame_end = frame_end;
        o_stat.out_free  = out_free;
        o_stat.div_busy  = div_busy;
    end

    assign o_out_valid  = r_out_valid;
    assign o_word_index = r_out_index;
    assign o_word_value = r_out_value;
    assign o_last_word  = r_out_last;

endmodule

FILE: design/fps_ctrl.sv
module fps_ctrl import fps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_fps_stat i_stat,
    output t_fps_cmd  o_cmd
);

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_FLUSH  = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_SEND   = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [WORD_IDX_W-1:0] r_word_idx;
    logic [WORD_IDX_W-1:0] n_word_idx;

    always_comb begin
        n_state        = r_state;
        n_word_idx     = r_word_idx;
        o_cmd          = '0;
        o_cmd.word_idx = r_word_idx;
        unique case (r_state)
            ST_RUN: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.frame_end) begin
                    n_state = ST_FLUSH;
                end
            end
            // let the last pixel's luma reach the accumulator
            ST_FLUSH: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (!i_stat.div_busy) begin
                    n_state    = ST_SEND;
                    n_word_idx = WORD_BYTE_COUNT;
                end
            end
            ST_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.send = 1'b1;
                    if (r_word_idx == WORD_CORNERS_BOT) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_RUN;
                    end else begin
                        n_word_idx = r_word_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RUN;
            r_word_idx <= WORD_BYTE_COUNT;
        end else begin
            r_state    <= n_state;
            r_word_idx <= n_word_idx;
        end
    end

    assign o_in_ready = (r_state == ST_RUN);

endmodule

FILE: design/fps_checker.sv
module fps_checker import fps_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [WORD_IDX_W-1:0] o_word_index,
    input logic [WORD_W-1:0]     o_word_value,
    input logic                  o_last_word
);

    // A stalled report transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_word_index) && $stable(o_word_value)
            && $stable(o_last_word))
        else $error("report word changed while stalled");

    // The last flag marks the final corner word only
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_word == (o_word_index == WORD_CORNERS_BOT)))
        else $error("last flag does not match word index");

    // No pixel is taken while a report is still being sent
    a_no_pixel_mid_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_index != WORD_CORNERS_BOT |-> !o_in_ready)
        else $error("pixel accepted during report");

    // A report always opens with the byte count word
    a_report_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_word_index == WORD_BYTE_COUNT)
        else $error("report did not start at word zero");

endmodule

bind frame_pixel_statistics_core fps_checker u_fps_checker (.*);
